// ----- src/ow_pkg.sv -----
// Shared types and constants for the one-wire bus master.
package ow_pkg;

	localparam int BITS_PER_BYTE_DEF = 8;
	localparam int COUNT_WIDTH_DEF   = 10;

	localparam int NUM_REGS  = 8;
	localparam int REG_W     = 10;
	localparam int REG_IDX_W = 3;
	localparam int BYTE_W    = 8;
	localparam int BIT_IDX_W = 4;
	localparam int OP_W      = 2;

	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = 1;
	localparam int Q_CW    = 2;

	localparam logic [REG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_RESET_TAIL    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_WRITE_ONE_LOW = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_WRITE_ZERO_LOW = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_SLOT          = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_READ_LOW      = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_READ_SAMPLE   = 3'd7;

	localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
	localparam logic [OP_W-1:0] OP_RESET = 2'd1;
	localparam logic [OP_W-1:0] OP_WRITE = 2'd2;
	localparam logic [OP_W-1:0] OP_READ  = 2'd3;

	typedef logic [NUM_REGS-1:0][REG_W-1:0] cfg_regs_t;

	localparam cfg_regs_t CFG_RESET_VALS = {
		10'd10, 10'd5, 10'd60, 10'd50, 10'd10, 10'd250, 10'd60, 10'd500
	};

	typedef enum logic [1:0] {
		CMD_TICK,
		CMD_RESET,
		CMD_WRITE,
		CMD_READ
	} cmd_t;

	typedef struct packed {
		cmd_t              kind;
		logic [BYTE_W-1:0] data;
		logic              lvl;
	} q_entry_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_RST_LOW,
		PH_RST_WAIT,
		PH_RST_TAIL,
		PH_WRITE,
		PH_READ
	} phase_t;

endpackage

// ----- src/ow_front.sv -----
// Input side: takes beats, classifies the opcode and queues them for the sequencer.
module ow_front import ow_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [OP_W-1:0]   op,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              line_level,
	output logic              q_valid,
	output q_entry_t          q_head,
	input  logic              q_pop
);

	q_entry_t              mem_q [Q_DEPTH];
	logic [Q_AW-1:0]       wr_ptr_q;
	logic [Q_AW-1:0]       rd_ptr_q;
	logic [Q_CW-1:0]       count_q;
	q_entry_t              entry;
	logic                  push;
	logic                  pop;

	assign in_ready = count_q != Q_CW'(Q_DEPTH);
	assign push     = in_valid && in_ready;
	assign q_valid  = count_q != '0;
	assign pop      = q_pop && q_valid;
	assign q_head   = mem_q[rd_ptr_q];

	always_comb begin
		entry.data = data_byte;
		entry.lvl  = line_level;
		case (op)
			OP_TICK:  entry.kind = CMD_TICK;
			OP_RESET: entry.kind = CMD_RESET;
			OP_WRITE: entry.kind = CMD_WRITE;
			OP_READ:  entry.kind = CMD_READ;
			default:  entry.kind = CMD_TICK;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			end
			count_q <= count_q + Q_CW'(push) - Q_CW'(pop);
		end
	end

endmodule

// ----- src/ow_back.sv -----
// Sequencer: runs reset, write and read slots on tick beats and registers each result.
module ow_back import ow_pkg::*; #(
	parameter int BITS_PER_BYTE = BITS_PER_BYTE_DEF,
	parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_regs_t         cfg,
	input  logic              q_valid,
	input  q_entry_t          q_head,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              line_low,
	output logic              busy_res,
	output logic              done_res,
	output logic              presence,
	output logic [BYTE_W-1:0] read_byte,
	output logic              rejected
);

	localparam int XW = (COUNT_WIDTH > REG_W + 1) ? COUNT_WIDTH : REG_W + 1;
	localparam logic [XW-1:0] CMAX_X = XW'({COUNT_WIDTH{1'b1}});
	localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

	function automatic logic [COUNT_WIDTH-1:0] clampc(input logic [XW-1:0] v);
		clampc = (v > CMAX_X) ? CMAX_X[COUNT_WIDTH-1:0] : v[COUNT_WIDTH-1:0];
	endfunction

	function automatic logic [COUNT_WIDTH-1:0] atleast1(input logic [XW-1:0] v);
		logic [COUNT_WIDTH-1:0] c;
		c = clampc(v);
		atleast1 = (c == '0) ? CNT_ONE : c;
	endfunction

	phase_t                  phase_q, phase_d;
	logic [COUNT_WIDTH-1:0]  tc_q, tc_d, tc_inc;
	logic [BIT_IDX_W-1:0]    bi_q, bi_d, bi_inc;
	logic [BYTE_W-1:0]       sb_q, sb_d, sb_rd;
	logic                    pres_q, pres_d;
	logic [BYTE_W-1:0]       last_q, last_d;
	logic                    rej_d, done_d, drive_d;

	logic [COUNT_WIDTH-1:0]  len_rst_low, len_wait, len_tail, len_slot, len_rd_low;
	logic [COUNT_WIDTH-1:0]  len_wr_low, rd_point, rd_sum;

	logic                    out_valid_q;
	logic                    line_low_q, busy_q, done_q, pres_out_q, rej_q;
	logic [BYTE_W-1:0]       rbyte_q;

	assign q_pop = q_valid && (!out_valid_q || out_ready);

	assign len_rst_low = atleast1(XW'(cfg[REG_RESET_LOW]));
	assign len_wait    = atleast1(XW'(cfg[REG_PRESENCE_WAIT]));
	assign len_tail    = clampc(XW'(cfg[REG_RESET_TAIL]));
	assign len_slot    = atleast1(XW'(cfg[REG_SLOT]));
	assign len_rd_low  = clampc(XW'(cfg[REG_READ_LOW]));
	assign rd_sum      = clampc(XW'(cfg[REG_READ_LOW]) + XW'(cfg[REG_READ_SAMPLE]));
	assign rd_point    = (rd_sum > len_slot) ? len_slot : ((rd_sum == '0) ? CNT_ONE : rd_sum);

	assign tc_inc = (tc_q == {COUNT_WIDTH{1'b1}}) ? tc_q : tc_q + CNT_ONE;
	assign bi_inc = bi_q + BIT_IDX_W'(1);

	// next state
	always_comb begin
		phase_d = phase_q;
		tc_d    = tc_q;
		bi_d    = bi_q;
		sb_d    = sb_q;
		pres_d  = pres_q;
		last_d  = last_q;
		rej_d   = 1'b0;
		done_d  = 1'b0;
		sb_rd   = {q_head.lvl, sb_q[BYTE_W-1:1]};
		if (q_head.kind != CMD_TICK) begin
			if (phase_q != PH_IDLE) begin
				rej_d = 1'b1;
			end else begin
				tc_d = '0;
				bi_d = '0;
				case (q_head.kind)
					CMD_RESET: begin
						phase_d = PH_RST_LOW;
						pres_d  = 1'b0;
					end
					CMD_WRITE: begin
						phase_d = PH_WRITE;
						sb_d    = q_head.data;
					end
					default: begin
						phase_d = PH_READ;
						sb_d    = '0;
					end
				endcase
			end
		end else begin
			case (phase_q)
				PH_IDLE: begin
				end
				PH_RST_LOW: begin
					tc_d = tc_inc;
					if (tc_inc >= len_rst_low) begin
						phase_d = PH_RST_WAIT;
						tc_d    = '0;
					end
				end
				PH_RST_WAIT: begin
					tc_d = tc_inc;
					if (tc_inc >= len_wait) begin
						pres_d = !q_head.lvl;
						tc_d   = '0;
						if (len_tail == '0) begin
							phase_d = PH_IDLE;
							done_d  = 1'b1;
						end else begin
							phase_d = PH_RST_TAIL;
						end
					end
				end
				PH_RST_TAIL: begin
					tc_d = tc_inc;
					if (tc_inc >= len_tail) begin
						phase_d = PH_IDLE;
						tc_d    = '0;
						done_d  = 1'b1;
					end
				end
				PH_WRITE: begin
					tc_d = tc_inc;
					if (tc_inc >= len_slot) begin
						sb_d = sb_q >> 1;
						tc_d = '0;
						bi_d = bi_inc;
						if (bi_inc >= BIT_IDX_W'(BITS_PER_BYTE)) begin
							phase_d = PH_IDLE;
							done_d  = 1'b1;
						end
					end
				end
				PH_READ: begin
					tc_d = tc_inc;
					if (tc_inc == rd_point) begin
						sb_d = sb_rd;
					end
					if (tc_inc >= len_slot) begin
						tc_d = '0;
						bi_d = bi_inc;
						if (bi_inc >= BIT_IDX_W'(BITS_PER_BYTE)) begin
							last_d  = (tc_inc == rd_point) ? sb_rd : sb_q;
							phase_d = PH_IDLE;
							done_d  = 1'b1;
						end
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	// line drive from the updated state
	always_comb begin
		len_wr_low = clampc(XW'(sb_d[0] ? cfg[REG_WRITE_ONE_LOW] : cfg[REG_WRITE_ZERO_LOW]));
		case (phase_d)
			PH_RST_LOW: drive_d = 1'b1;
			PH_WRITE:   drive_d = tc_d < len_wr_low;
			PH_READ:    drive_d = tc_d < len_rd_low;
			default:    drive_d = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			tc_q        <= '0;
			bi_q        <= '0;
			sb_q        <= '0;
			pres_q      <= 1'b0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				phase_q     <= phase_d;
				tc_q        <= tc_d;
				bi_q        <= bi_d;
				sb_q        <= sb_d;
				pres_q      <= pres_d;
				last_q      <= last_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			line_low_q <= drive_d;
			busy_q     <= phase_d != PH_IDLE;
			done_q     <= done_d;
			pres_out_q <= pres_d;
			rbyte_q    <= last_d;
			rej_q      <= rej_d;
		end
	end

	assign out_valid = out_valid_q;
	assign line_low  = line_low_q;
	assign busy_res  = busy_q;
	assign done_res  = done_q;
	assign presence  = pres_out_q;
	assign read_byte = rbyte_q;
	assign rejected  = rej_q;

endmodule

// ----- src/one_wire_bus_master_core.sv -----
// Top level: one-wire bus master with timing registers, input queue and slot sequencer.
// Each beat passes through the input queue and then into the registered result.
// Throughput: one beat per cycle unless out_ready stalls the output register.
// Input queue of 2 beats and an output register decouple the two handshakes.
// Reset: asynchronous, clears sequencer, queue and output; timing registers reload defaults.
module one_wire_bus_master_core import ow_pkg::*; #(
	parameter int BITS_PER_BYTE = BITS_PER_BYTE_DEF,
	parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_idx,
	input  logic [REG_W-1:0]     cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [OP_W-1:0]      op,
	input  logic [BYTE_W-1:0]    data_byte,
	input  logic                 line_level,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 line_low,
	output logic                 busy_res,
	output logic                 done_res,
	output logic                 presence,
	output logic [BYTE_W-1:0]    read_byte,
	output logic                 rejected
);

	cfg_regs_t cfg_q;
	logic      q_valid;
	logic      q_pop;
	q_entry_t  q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET_VALS;
		end else if (cfg_we) begin
			cfg_q[cfg_idx] <= cfg_wdata;
		end
	end

	ow_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.data_byte  (data_byte),
		.line_level (line_level),
		.q_valid    (q_valid),
		.q_head     (q_head),
		.q_pop      (q_pop)
	);

	ow_back #(
		.BITS_PER_BYTE (BITS_PER_BYTE),
		.COUNT_WIDTH   (COUNT_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.line_low  (line_low),
		.busy_res  (busy_res),
		.done_res  (done_res),
		.presence  (presence),
		.read_byte (read_byte),
		.rejected  (rejected)
	);

endmodule

// ----- tb/one_wire_bus_master_core_tb.sv -----
// Testbench for the one-wire bus master core: directed and random beats checked against a predictor.
`timescale 1ns / 100ps

module one_wire_bus_master_core_tb;
	import ow_pkg::*;

	localparam int CNT_MAX = (1 << COUNT_WIDTH_DEF) - 1;
	localparam logic [REG_W-1:0] REG_ALL_ONES = '1;

	typedef struct packed {
		logic              drive;
		logic              busy;
		logic              done;
		logic              present;
		logic [BYTE_W-1:0] rbyte;
		logic              reject;
	} bus_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [REG_IDX_W-1:0] cfg_idx = '0;
	logic [REG_W-1:0]     cfg_wdata = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [OP_W-1:0]      op = OP_TICK;
	logic [BYTE_W-1:0]    data_byte = '0;
	logic                 line_level = 1'b1;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 line_low;
	logic                 busy_res;
	logic                 done_res;
	logic                 presence;
	logic [BYTE_W-1:0]    read_byte;
	logic                 rejected;

	// predictor state
	cfg_regs_t         timing = CFG_RESET_VALS;
	phase_t            bus_phase = PH_IDLE;
	int                tick_count = 0;
	logic [3:0]        bit_pos = '0;
	logic [BYTE_W-1:0] shift_reg = '0;
	logic              presence_seen = 1'b0;
	logic [BYTE_W-1:0] last_read = '0;

	bus_result_t expected_results[$];
	int          mismatch_count = 0;
	int          beats_sent = 0;
	int          sender_idle_pct = 18;
	int          receiver_idle_pct = 64;

	one_wire_bus_master_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.data_byte  (data_byte),
		.line_level (line_level),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.line_low   (line_low),
		.busy_res   (busy_res),
		.done_res   (done_res),
		.presence   (presence),
		.read_byte  (read_byte),
		.rejected   (rejected)
	);

	always #2 clk = ~clk;

	function automatic int clamp_count(int v);
		return (v > CNT_MAX) ? CNT_MAX : v;
	endfunction

	function automatic int min_one(int v);
		return (clamp_count(v) == 0) ? 1 : clamp_count(v);
	endfunction

	function automatic logic bit_slot_over();
		tick_count = 0;
		bit_pos = bit_pos + 4'd1;
		return bit_pos >= BITS_PER_BYTE_DEF;
	endfunction

	function automatic bus_result_t predict_step(logic [OP_W-1:0] cmd, logic [BYTE_W-1:0] data,
			logic lvl);
		bus_result_t r;
		int slot;
		int point;
		r = '0;
		if (cmd != OP_TICK) begin
			if (bus_phase != PH_IDLE) begin
				r.reject = 1'b1;
			end else begin
				tick_count = 0;
				bit_pos = '0;
				case (cmd)
					OP_RESET: begin
						bus_phase = PH_RST_LOW;
						presence_seen = 1'b0;
					end
					OP_WRITE: begin
						bus_phase = PH_WRITE;
						shift_reg = data;
					end
					default: begin
						bus_phase = PH_READ;
						shift_reg = '0;
					end
				endcase
			end
		end else if (bus_phase != PH_IDLE) begin
			if (tick_count < CNT_MAX)
				tick_count++;
			case (bus_phase)
				PH_RST_LOW: begin
					if (tick_count >= min_one(timing[REG_RESET_LOW])) begin
						bus_phase = PH_RST_WAIT;
						tick_count = 0;
					end
				end
				PH_RST_WAIT: begin
					if (tick_count >= min_one(timing[REG_PRESENCE_WAIT])) begin
						presence_seen = ~lvl;
						tick_count = 0;
						if (clamp_count(timing[REG_RESET_TAIL]) == 0) begin
							bus_phase = PH_IDLE;
							r.done = 1'b1;
						end else begin
							bus_phase = PH_RST_TAIL;
						end
					end
				end
				PH_RST_TAIL: begin
					if (tick_count >= clamp_count(timing[REG_RESET_TAIL])) begin
						bus_phase = PH_IDLE;
						tick_count = 0;
						r.done = 1'b1;
					end
				end
				PH_WRITE: begin
					if (tick_count >= min_one(timing[REG_SLOT])) begin
						shift_reg = shift_reg >> 1;
						if (bit_slot_over()) begin
							bus_phase = PH_IDLE;
							r.done = 1'b1;
						end
					end
				end
				PH_READ: begin
					slot = min_one(timing[REG_SLOT]);
					point = clamp_count(int'(timing[REG_READ_LOW]) + int'(timing[REG_READ_SAMPLE]));
					if (point > slot)
						point = slot;
					if (point == 0)
						point = 1;
					if (tick_count == point)
						shift_reg = {lvl, shift_reg[BYTE_W-1:1]};
					if (tick_count >= slot) begin
						if (bit_slot_over()) begin
							last_read = shift_reg;
							bus_phase = PH_IDLE;
							r.done = 1'b1;
						end
					end
				end
				default: bus_phase = PH_IDLE;
			endcase
		end
		case (bus_phase)
			PH_RST_LOW: r.drive = 1'b1;
			PH_WRITE: r.drive = tick_count < clamp_count(shift_reg[0] ?
				timing[REG_WRITE_ONE_LOW] : timing[REG_WRITE_ZERO_LOW]);
			PH_READ: r.drive = tick_count < clamp_count(timing[REG_READ_LOW]);
			default: r.drive = 1'b0;
		endcase
		r.busy = bus_phase != PH_IDLE;
		r.present = presence_seen;
		r.rbyte = last_read;
		return r;
	endfunction

	task automatic note_mismatch(string what, int unsigned want, int unsigned got);
		$display("%0t ns: %s mismatch, expected 0x%0h got 0x%0h", $time, what, want, got);
		mismatch_count++;
	endtask

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= receiver_idle_pct);

	always @(posedge clk) begin
		bus_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				note_mismatch("unexpected beat", 0, 1);
			end else begin
				want = expected_results.pop_front();
				if (line_low !== want.drive)
					note_mismatch("line_low", want.drive, line_low);
				if (busy_res !== want.busy)
					note_mismatch("busy_res", want.busy, busy_res);
				if (done_res !== want.done)
					note_mismatch("done_res", want.done, done_res);
				if (presence !== want.present)
					note_mismatch("presence", want.present, presence);
				if (read_byte !== want.rbyte)
					note_mismatch("read_byte", want.rbyte, read_byte);
				if (rejected !== want.reject)
					note_mismatch("rejected", want.reject, rejected);
			end
		end
	end

	// called at a falling edge; returns at a falling edge with valid still high
	task automatic send_beat(logic [OP_W-1:0] cmd, logic [BYTE_W-1:0] data, logic lvl);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op <= cmd;
		data_byte <= data;
		line_level <= lvl;
		do @(posedge clk); while (!in_ready);
		expected_results.push_back(predict_step(cmd, data, lvl));
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (expected_results.size() != 0 && waited < 5000) begin
			@(negedge clk);
			waited++;
		end
		if (expected_results.size() != 0) begin
			note_mismatch("missing beats", expected_results.size(), 0);
			expected_results.delete();
		end
		repeat (4) @(negedge clk);
	endtask

	// pipeline must be drained first
	task automatic program_timing(cfg_regs_t vals);
		for (int i = 0; i < NUM_REGS; i++) begin
			cfg_we <= 1'b1;
			cfg_idx <= REG_IDX_W'(i);
			cfg_wdata <= vals[i];
			@(negedge clk);
			timing[i] = vals[i];
		end
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic finish_sequence(int noise_pct);
		while (bus_phase != PH_IDLE) begin
			if ($urandom_range(99) < noise_pct)
				send_beat(OP_W'($urandom_range(3, 1)), BYTE_W'($urandom_range(255)),
					1'($urandom_range(1)));
			else
				send_beat(OP_TICK, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
		end
	endtask

	function automatic int pick_pulse();
		case ($urandom_range(3))
			0: return 0;
			1: return REG_ALL_ONES;
			2: return $urandom_range(8);
			default: return $urandom_range(CNT_MAX);
		endcase
	endfunction

	function automatic cfg_regs_t random_timing();
		cfg_regs_t v;
		v[REG_RESET_LOW]      = REG_W'($urandom_range(6));
		v[REG_PRESENCE_WAIT]  = REG_W'($urandom_range(6));
		v[REG_RESET_TAIL]     = REG_W'($urandom_range(6));
		v[REG_SLOT]           = REG_W'($urandom_range(6));
		v[REG_WRITE_ONE_LOW]  = REG_W'(pick_pulse());
		v[REG_WRITE_ZERO_LOW] = REG_W'(pick_pulse());
		v[REG_READ_LOW]       = REG_W'(pick_pulse());
		v[REG_READ_SAMPLE]    = REG_W'(pick_pulse());
		return v;
	endfunction

	// idle ticks, a reset under default timing, commands while busy, retimed mid-reset
	task automatic test_idle_and_busy();
		cfg_regs_t tiny;
		tiny = '0;
		tiny[REG_WRITE_ZERO_LOW] = REG_ALL_ONES;
		send_beat(OP_TICK, 8'hFF, 1'b0);
		send_beat(OP_TICK, 8'h00, 1'b1);
		send_beat(OP_RESET, 8'h00, 1'b1);
		send_beat(OP_TICK, 8'h55, 1'b1);
		send_beat(OP_WRITE, 8'hFF, 1'b0);
		send_beat(OP_READ, 8'hAA, 1'b1);
		send_beat(OP_RESET, 8'h0F, 1'b0);
		drain_results();
		program_timing(tiny);
		send_beat(OP_TICK, 8'h00, 1'b0);
		send_beat(OP_TICK, 8'hF0, 1'b0);
		finish_sequence(0);
	endtask

	// zero slot, zero and long low pulses, sample point below one
	task automatic test_write_read_directed();
		send_beat(OP_WRITE, 8'h5A, 1'b1);
		finish_sequence(0);
		send_beat(OP_READ, 8'h00, 1'b0);
		finish_sequence(0);
	endtask

	// all registers at full scale, then cleared while a read is running
	task automatic test_register_extremes();
		drain_results();
		program_timing('1);
		send_beat(OP_READ, 8'hC3, 1'b1);
		repeat (30) send_beat(OP_TICK, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
		send_beat(OP_WRITE, 8'h81, 1'b0);
		drain_results();
		program_timing('0);
		finish_sequence(0);
		send_beat(OP_RESET, 8'h00, 1'b1);
		finish_sequence(0);
		send_beat(OP_WRITE, 8'h00, 1'b0);
		finish_sequence(0);
	endtask

	task automatic test_random_traffic(int send_pct, int recv_pct);
		int chunk_start;
		sender_idle_pct = send_pct;
		receiver_idle_pct = recv_pct;
		repeat (4) begin
			drain_results();
			program_timing(random_timing());
			chunk_start = beats_sent;
			while (beats_sent - chunk_start < 60) begin
				if ($urandom_range(99) < 3)
					drain_results();
				if ($urandom_range(99) < 10)
					send_beat(OP_TICK, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
				send_beat(OP_W'($urandom_range(3, 1)), BYTE_W'($urandom_range(255)),
					1'($urandom_range(1)));
				finish_sequence(6);
			end
		end
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_idle_and_busy();
		test_write_read_directed();
		test_register_extremes();
		test_random_traffic(18, 64);
		test_random_traffic(64, 18);
		test_random_traffic(0, 0);
		drain_results();
		repeat (10) @(negedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
